### sv/mcdma_pkg.sv
// Package with shared types and constants of the multi-channel DMA controller.
`default_nettype none
package mcdma_pkg;
   localparam int NumChannelsDefault = 7;
   localparam int AddrBitsDefault = 24;
   localparam int DisplayCh = 2;
   localparam int ClearCh = 6;
   localparam logic [31:0] PriorityReset = 32'h0765_4321;
   localparam logic [23:0] ListEnd = 24'hFF_FFFF;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] SEL_ADDR = 2'd0;
   localparam logic [1:0] SEL_BLOCK = 2'd1;
   localparam logic [1:0] SEL_CTRL = 2'd2;
   localparam logic [1:0] SEL_PRIO = 2'd0;
   localparam logic [1:0] SEL_IRQ = 2'd1;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_DISPLAY = 2'd1;
   localparam logic [1:0] ACT_MEMORY = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] reg_channel;
      logic [1:0] reg_select;
      logic [31:0] write_data;
      logic [31:0] mem_data;
   } item_type;
endpackage
`default_nettype wire

### sv/mcdma_front.sv
// Front end: accepts items into a two-entry queue.
`default_nettype none
module mcdma_front
   import mcdma_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire item_type push_item,
   input wire logic pop,
   output logic full,
   output logic not_empty,
   output item_type head_item
);
   item_type q_ff [2];
   item_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = push_item;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

   assign full = cnt_ff[1];
   assign not_empty = cnt_ff != 2'd0;
   assign head_item = q_ff[0];
endmodule
`default_nettype wire

### sv/mcdma_back.sv
// Back end: channel registers, transfer steps and result register.
`default_nettype none
module mcdma_back
   import mcdma_pkg::*;
#(
   parameter int NUM_CHANNELS = NumChannelsDefault,
   parameter int ADDR_BITS = AddrBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic go,
   input wire item_type it,
   output logic done,
   output logic [31:0] rsp_read_data,
   output logic [1:0] rsp_bus_action,
   output logic [23:0] rsp_action_addr,
   output logic [31:0] rsp_action_data,
   output logic [23:0] rsp_next_fetch_addr,
   output logic rsp_irq_pulse,
   output logic rsp_channel_ran
);
   localparam logic [ADDR_BITS-1:0] Four = ADDR_BITS'(4);
   localparam int Nc = NUM_CHANNELS;

   logic [ADDR_BITS-1:0] addr_ff [Nc], addr_in [Nc];
   logic [31:0] block_ff [Nc], block_in [Nc];
   logic [31:0] count_ff [Nc], count_in [Nc];
   logic [23:0] link_ff [Nc], link_in [Nc];
   logic [10:0] ctrl_ff [Nc], ctrl_in [Nc];
   logic [Nc-1:0] active_ff, active_in;
   logic [Nc-1:0] cbusy_ff, cbusy_in;
   logic [31:0] prio_ff, prio_in;
   logic [6:0] mask_ff, mask_in, stat_ff, stat_in;
   logic force_ff, force_in, master_ff, master_in;
   logic ph_ff, ph_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] rd_ff, rd_in, ad_ff, ad_in;
   logic [1:0] act_ff, act_in;
   logic [23:0] aa_ff, aa_in, nf_ff, nf_in;
   logic pulse_ff, pulse_in, ran_ff, ran_in, done_ff, done_in;

   logic [2:0] ch;
   logic found, line_before, line_after;
   logic [10:0] fld;
   logic [31:0] newcnt;
   logic [ADDR_BITS-1:0] na;
   logic [2:0] pc;
   logic pfound;

   always_comb begin
      addr_in = addr_ff; block_in = block_ff; count_in = count_ff;
      link_in = link_ff; ctrl_in = ctrl_ff; active_in = active_ff;
      cbusy_in = cbusy_ff; prio_in = prio_ff; mask_in = mask_ff;
      stat_in = stat_ff; force_in = force_ff; master_in = master_ff;
      ph_in = ph_ff; prod_in = prod_ff;
      rd_in = 32'd0; act_in = ACT_NONE; aa_in = 24'd0; ad_in = 32'd0;
      pulse_in = 1'b0; ran_in = 1'b0; done_in = 1'b0; nf_in = nf_ff;
      ch = 3'd0; found = 1'b0; fld = 11'd0; newcnt = 32'd0;
      na = '0; pc = 3'd0; pfound = 1'b0;
      line_before = master_ff && ((stat_ff & mask_ff) != 7'd0);
      line_after = line_before;
      for (int i = Nc - 1; i >= 0; i--) begin
         if (prio_ff[i*4+3] && active_ff[i]) begin
            ch = 3'(i);
            found = 1'b1;
         end
      end
      if (go && !ph_ff) begin
         prod_in = 32'(block_ff[it.reg_channel][15:0]) * 32'(block_ff[it.reg_channel][31:16]);
         ph_in = 1'b1;
      end else if (go) begin
         ph_in = 1'b0;
         done_in = 1'b1;
         case (it.operation)
            OP_WRITE: begin
               if (it.reg_channel != 3'd7) begin
                  case (it.reg_select)
                     SEL_ADDR: addr_in[it.reg_channel] = ADDR_BITS'(it.write_data[23:0]);
                     SEL_BLOCK: block_in[it.reg_channel] = it.write_data;
                     SEL_CTRL: begin
                        fld = {it.write_data[22:20], it.write_data[18:16],
                               it.write_data[10:9], it.write_data[8],
                               it.write_data[1], it.write_data[0]};
                        ctrl_in[it.reg_channel] = fld;
                        if (!active_ff[it.reg_channel] && it.write_data[24]) begin
                           case (fld[4:3])
                              2'd0: count_in[it.reg_channel] =
                                 (block_ff[it.reg_channel][15:0] != 16'd0) ?
                                 32'(block_ff[it.reg_channel][15:0]) : 32'h1_0000;
                              2'd1: count_in[it.reg_channel] = prod_ff;
                              2'd2: begin
                                 count_in[it.reg_channel] = 32'd0;
                                 link_in[it.reg_channel] =
                                    24'(addr_ff[it.reg_channel]);
                              end
                              default: ;
                           endcase
                        end
                        active_in[it.reg_channel] = it.write_data[24];
                        cbusy_in[it.reg_channel] = it.write_data[28];
                     end
                     default: ;
                  endcase
               end else begin
                  case (it.reg_select)
                     SEL_PRIO: prio_in = it.write_data;
                     SEL_IRQ: begin
                        force_in = it.write_data[15];
                        mask_in = it.write_data[22:16];
                        master_in = it.write_data[23];
                        stat_in = stat_ff & ~it.write_data[30:24];
                     end
                     default: ;
                  endcase
               end
            end
            OP_READ: begin
               if (it.reg_channel != 3'd7) begin
                  if (it.reg_select == SEL_CTRL) begin
                     fld = ctrl_ff[it.reg_channel];
                     rd_in = {7'd0, active_ff[it.reg_channel], 1'b0, fld[10:8],
                              1'b0, fld[7:5], 5'd0, fld[4:3], fld[2], 6'd0, fld[1], fld[0]};
                  end
               end else if (it.reg_select == SEL_PRIO) begin
                  rd_in = prio_ff;
               end else if (it.reg_select == SEL_IRQ) begin
                  rd_in = {force_ff || line_before, stat_ff, master_ff, mask_ff,
                           force_ff, 15'd0};
               end
            end
            OP_TICK: begin
               if (found) begin
                  ran_in = 1'b1;
                  if (ch == 3'(DisplayCh)) begin
                     if (ctrl_ff[ch][4:3] == 2'd1) begin
                        act_in = ACT_DISPLAY;
                        ad_in = it.mem_data;
                        newcnt = count_ff[ch] - 32'd1;
                        count_in[ch] = newcnt;
                        addr_in[ch] = addr_ff[ch] + Four;
                        if (newcnt == 32'd0) begin
                           active_in[ch] = 1'b0; cbusy_in[ch] = 1'b0;
                           stat_in[ch] = 1'b1;
                        end
                     end else if (ctrl_ff[ch][4:3] == 2'd2) begin
                        if (count_ff[ch] == 32'd0) begin
                           if (link_ff[ch] == ListEnd) begin
                              active_in[ch] = 1'b0; cbusy_in[ch] = 1'b0;
                              stat_in[ch] = 1'b1;
                           end else begin
                              addr_in[ch] = ADDR_BITS'(link_ff[ch]);
                              link_in[ch] = it.mem_data[23:0];
                              count_in[ch] = 32'(it.mem_data[31:24]);
                           end
                        end else begin
                           count_in[ch] = count_ff[ch] - 32'd1;
                           addr_in[ch] = addr_ff[ch] + Four;
                           act_in = ACT_DISPLAY;
                           ad_in = it.mem_data;
                        end
                     end
                  end else if (ch == 3'(ClearCh)) begin
                     act_in = ACT_MEMORY;
                     aa_in = 24'(addr_ff[ch]);
                     newcnt = count_ff[ch] - 32'd1;
                     count_in[ch] = newcnt;
                     if (newcnt == 32'd0) begin
                        ad_in = 32'(ListEnd);
                        active_in[ch] = 1'b0; cbusy_in[ch] = 1'b0;
                        stat_in[ch] = 1'b1;
                     end else begin
                        na = addr_ff[ch] - Four;
                        ad_in = 32'(na);
                        addr_in[ch] = na;
                     end
                  end
                  line_after = master_ff && ((stat_in & mask_ff) != 7'd0);
                  pulse_in = !line_before && line_after;
               end
            end
            default: ;
         endcase
         for (int i = Nc - 1; i >= 0; i--) begin
            if (prio_in[i*4+3] && active_in[i]) begin
               pc = 3'(i);
               pfound = 1'b1;
            end
         end
         nf_in = 24'd0;
         if (pfound && pc == 3'(DisplayCh)) begin
            if (ctrl_in[pc][4:3] == 2'd1) begin
               nf_in = 24'(addr_in[pc]);
            end else if (ctrl_in[pc][4:3] == 2'd2) begin
               if (count_in[pc] == 32'd0) begin
                  nf_in = (link_in[pc] == ListEnd) ? 24'd0 :
                          24'(ADDR_BITS'(link_in[pc]));
               end else begin
                  nf_in = 24'(addr_in[pc] + Four);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Nc; i++) begin
            addr_ff[i] <= '0; block_ff[i] <= '0; count_ff[i] <= '0;
            link_ff[i] <= '0; ctrl_ff[i] <= '0;
         end
         active_ff <= '0; cbusy_ff <= '0; prio_ff <= PriorityReset;
         mask_ff <= '0; stat_ff <= '0; force_ff <= 1'b0; master_ff <= 1'b0;
         ph_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         addr_ff <= addr_in; block_ff <= block_in; count_ff <= count_in;
         link_ff <= link_in; ctrl_ff <= ctrl_in; active_ff <= active_in;
         cbusy_ff <= cbusy_in; prio_ff <= prio_in; mask_ff <= mask_in;
         stat_ff <= stat_in; force_ff <= force_in; master_ff <= master_in;
         ph_ff <= ph_in; done_ff <= done_in;
      end
      prod_ff <= prod_in;
      rd_ff <= rd_in; act_ff <= act_in; aa_ff <= aa_in; ad_ff <= ad_in;
      nf_ff <= nf_in; pulse_ff <= pulse_in; ran_ff <= ran_in;
   end

   assign done = done_in;
   assign rsp_read_data = done_ff ? rd_ff : 32'd0;
   assign rsp_bus_action = done_ff ? act_ff : ACT_NONE;
   assign rsp_action_addr = done_ff ? aa_ff : 24'd0;
   assign rsp_action_data = done_ff ? ad_ff : 32'd0;
   assign rsp_next_fetch_addr = nf_ff;
   assign rsp_irq_pulse = done_ff & pulse_ff;
   assign rsp_channel_ran = done_ff & ran_ff;
   logic unused;
   assign unused = ^cbusy_ff;
   logic strobe_unused;
   assign strobe_unused = unused;
endmodule
`default_nettype wire

### sv/multi_channel_dma_controller.sv
// Top level of the seven-channel DMA controller.
`default_nettype none
// Usage:
// An item (register write, register read or tick) is offered on the req_ ports
// with start; it is taken at an edge where start is high and busy is low.
// Items enter a two-entry queue; the back end executes each item in a product
// phase, which forms the 16x16 block product, and then an apply phase, which
// applies the register update or transfer step and registers the result.
// Each item yields exactly one result, shown on the rsp_ ports for one cycle
// with rsp_valid high, once the back end has registered the result.
// The back end works on one item at a time; the queue takes new items until full.
// busy is high while the queue is full.
// The receiver cannot stall; results are never held back.
// Reset clears all channel registers, sets the priority word to 0x07654321
// and empties the queue. No clearing pass is needed.
// On a tick, mem_data must carry the word at the last rsp_next_fetch_addr.
module multi_channel_dma_controller
   import mcdma_pkg::*;
#(
   parameter int NUM_CHANNELS = NumChannelsDefault,
   parameter int ADDR_BITS = AddrBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_operation,
   input wire logic [2:0] req_reg_channel,
   input wire logic [1:0] req_reg_select,
   input wire logic [31:0] req_write_data,
   input wire logic [31:0] req_mem_data,
   output logic rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic [1:0] rsp_bus_action,
   output logic [23:0] rsp_action_addr,
   output logic [31:0] rsp_action_data,
   output logic [23:0] rsp_next_fetch_addr,
   output logic rsp_irq_pulse,
   output logic rsp_channel_ran
);
   item_type in_item, head;
   logic full, ne, pop;
   logic valid_ff;

   assign in_item = '{operation: req_operation, reg_channel: req_reg_channel,
                      reg_select: req_reg_select, write_data: req_write_data,
                      mem_data: req_mem_data};
   assign busy = full;

   mcdma_front u_front (
      .clock(clock), .reset(reset), .push(start && !full), .push_item(in_item),
      .pop(pop), .full(full), .not_empty(ne), .head_item(head)
   );

   mcdma_back #(.NUM_CHANNELS(NUM_CHANNELS), .ADDR_BITS(ADDR_BITS)) u_back (
      .clock(clock), .reset(reset), .go(ne), .it(head), .done(pop),
      .rsp_read_data(rsp_read_data), .rsp_bus_action(rsp_bus_action),
      .rsp_action_addr(rsp_action_addr), .rsp_action_data(rsp_action_data),
      .rsp_next_fetch_addr(rsp_next_fetch_addr), .rsp_irq_pulse(rsp_irq_pulse),
      .rsp_channel_ran(rsp_channel_ran)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pop;
      end
   end
   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire
